// ----- rtl/mrt_pkg.sv -----
// shared types and constants for the memory map region table
package mrt_pkg;

    localparam int DATA_W          = 64;
    localparam int KIND_W          = 8;
    localparam int MAX_REGIONS_DEF = 32;
    // a scan reports at most this many reserved regions, the rest are only counted
    localparam int RESULT_CAP      = 32;

    localparam logic [KIND_W-1:0] KIND_AVAILABLE = 8'd1;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_SCAN  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        RES_LOAD_ACK  = 2'd0,
        RES_QUERY     = 2'd1,
        RES_RESERVED  = 2'd2,
        RES_SCAN_DONE = 2'd3
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_QEND,
        S_QLOW,
        S_QOFF,
        S_QSPACE,
        S_QFIT,
        S_QDONE,
        S_RLI,
        S_RUP,
        S_RRD,
        S_RCHK,
        S_RDONE
    } state_t;

endpackage

// ----- rtl/mrt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/memory_map_region_table.sv -----
// memory map region table: loads regions, first-fit queries and reserve scans
// load ack is a registered beat; query walks the regions in order, skipping other types
//   and available regions ending below the limit, testing the rest, not-found if none fit
// scan (if enabled): reads the last available region, then each loaded region, then the
//   closing beat; a stalled result beat holds the scan; one item at a time, not ready meanwhile
// reset: async active-low clears count, sum, last index, enable, sequencer; not the table
module memory_map_region_table
    import mrt_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,

    // configuration
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,

    // input beats
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic              first_entry,
    input  logic [DATA_W-1:0] entry_base,
    input  logic [DATA_W-1:0] entry_length,
    input  logic [KIND_W-1:0] entry_kind,
    input  logic [DATA_W-1:0] min_address,
    input  logic [DATA_W-1:0] bytes_wanted,

    // result beats
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic [DATA_W-1:0] found_address,
    output logic [DATA_W-1:0] found_length,
    output logic              found,
    output logic [DATA_W-1:0] available_total,
    output logic [4:0]        last_available_slot,
    output logic [5:0]        loaded_count,
    output logic [5:0]        reserved_count,
    output logic              last
);

    // index and count widths follow the table depth
    localparam int IW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW      = $clog2(MAX_REGIONS + 1);
    localparam int ENTRY_W = KIND_W + 2 * DATA_W;

    // sequencer and status
    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [IW-1:0]     li_reg, li_next;
    logic [CW-1:0]     rcnt_reg, rcnt_next;
    logic              reserve_en_reg;

    // work registers
    logic [DATA_W-1:0] acc_reg, acc_next;      // end, offset, space, or scan upper bound
    logic [DATA_W-1:0] cand_reg, cand_next;    // candidate answer address
    logic [DATA_W-1:0] lower_reg, lower_next;
    logic [DATA_W-1:0] want_reg, want_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        okind_reg, okind_next;
    logic [DATA_W-1:0] oaddr_reg, oaddr_next;
    logic [DATA_W-1:0] olen_reg, olen_next;
    logic              ofound_reg, ofound_next;
    logic [CW-1:0]     orcnt_reg, orcnt_next;
    logic              olast_reg, olast_next;

    // table ram
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [DATA_W-1:0]  rd_base;
    logic [DATA_W-1:0]  rd_len;
    logic [KIND_W-1:0]  rd_kind;

    // shared adder/subtractor; carry out on subtract means a >= b
    logic [DATA_W-1:0] op_a, op_b;
    logic              op_sub;
    logic [DATA_W:0]   alu_full;
    logic [DATA_W-1:0] alu_res;
    logic              alu_carry;

    logic              in_accept;
    logic              slot_free;
    logic              last_idx;
    logic [CW-1:0]     slot_cnt;
    logic              slot_ok;

    mrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_base = ram_rdata[DATA_W-1:0];
    assign rd_len  = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_kind = ram_rdata[ENTRY_W-1:2*DATA_W];

    assign alu_full  = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)}
                     + {{DATA_W{1'b0}}, op_sub};
    assign alu_res   = alu_full[DATA_W-1:0];
    assign alu_carry = alu_full[DATA_W];

    // the output slot can take a new beat when empty or draining this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_accept = in_valid && in_ready;

    // current walk position is the last loaded region
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // load slot after an optional clear
    assign slot_cnt = first_entry ? '0 : count_reg;
    assign slot_ok  = (int'(slot_cnt) < MAX_REGIONS);

    assign ram_waddr = slot_cnt[IW-1:0];
    assign ram_wdata = {entry_kind, entry_length, entry_base};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            sum_reg        <= '0;
            li_reg         <= '0;
            reserve_en_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            li_reg        <= li_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                reserve_en_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rcnt_reg  <= rcnt_next;
        acc_reg   <= acc_next;
        cand_reg  <= cand_next;
        lower_reg <= lower_next;
        want_reg  <= want_next;
        okind_reg <= okind_next;
        oaddr_reg <= oaddr_next;
        olen_reg  <= olen_next;
        ofound_reg <= ofound_next;
        orcnt_reg <= orcnt_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        li_next        = li_reg;
        rcnt_next      = rcnt_reg;
        acc_next       = acc_reg;
        cand_next      = cand_reg;
        lower_next     = lower_reg;
        want_next      = want_reg;

        out_valid_next = out_valid_reg && !out_ready;
        okind_next     = okind_reg;
        oaddr_next     = oaddr_reg;
        olen_next      = olen_reg;
        ofound_next    = ofound_reg;
        orcnt_next     = orcnt_reg;
        olast_next     = olast_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;

        op_a   = rd_base;
        op_b   = rd_len;
        op_sub = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // the load sum goes through the shared adder
                op_a = first_entry ? '0 : sum_reg;
                op_b = entry_length;
                if (in_accept)
                begin
                    idx_next   = '0;
                    rcnt_next  = '0;
                    lower_next = min_address;
                    want_next  = bytes_wanted;
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            if (first_entry)
                            begin
                                count_next = '0;
                                sum_next   = '0;
                                li_next    = '0;
                            end
                            if (slot_ok)
                            begin
                                ram_we     = 1'b1;
                                count_next = slot_cnt + CW'(1);
                                if (entry_kind == KIND_AVAILABLE)
                                begin
                                    sum_next = alu_res;
                                    li_next  = slot_cnt[IW-1:0];
                                end
                            end
                            out_valid_next = 1'b1;
                            okind_next     = RES_LOAD_ACK;
                            oaddr_next     = '0;
                            olen_next      = '0;
                            ofound_next    = 1'b0;
                            orcnt_next     = '0;
                            olast_next     = 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            state_next = (count_reg == '0) ? S_QDONE : S_QRD;
                        end
                        FUNC_SCAN:
                        begin
                            state_next = reserve_en_reg ? S_RLI : S_RDONE;
                        end
                        default:
                        begin
                            // unused code: dropped with no beat
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // first-fit query walk
            S_QRD:
            begin
                ram_re     = 1'b1;
                state_next = S_QEND;
            end
            S_QEND:
            begin
                acc_next = alu_res;   // region end
                if (rd_kind != KIND_AVAILABLE)
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = last_idx ? S_QDONE : S_QRD;
                end
                else
                begin
                    state_next = S_QLOW;
                end
            end
            S_QLOW:
            begin
                op_a   = acc_reg;
                op_b   = lower_reg;
                op_sub = 1'b1;
                if (!alu_carry)
                begin
                    // region ends below the lower limit
                    idx_next   = idx_reg + IW'(1);
                    state_next = last_idx ? S_QDONE : S_QRD;
                end
                else
                begin
                    state_next = S_QOFF;
                end
            end
            S_QOFF:
            begin
                op_a       = lower_reg;
                op_b       = rd_base;
                op_sub     = 1'b1;
                acc_next   = alu_carry ? alu_res : '0;
                cand_next  = alu_carry ? lower_reg : rd_base;
                state_next = S_QSPACE;
            end
            S_QSPACE:
            begin
                op_a       = rd_len;
                op_b       = acc_reg;
                op_sub     = 1'b1;
                acc_next   = alu_res;
                state_next = S_QFIT;
            end
            S_QFIT:
            begin
                op_a   = acc_reg;
                op_b   = want_reg;
                op_sub = 1'b1;
                if (alu_carry)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        okind_next     = RES_QUERY;
                        oaddr_next     = cand_reg;
                        olen_next      = '0;
                        ofound_next    = 1'b1;
                        orcnt_next     = '0;
                        olast_next     = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = last_idx ? S_QDONE : S_QRD;
                end
            end
            S_QDONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    okind_next     = RES_QUERY;
                    oaddr_next     = '0;
                    olen_next      = '0;
                    ofound_next    = 1'b0;
                    orcnt_next     = '0;
                    olast_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // reserve scan
            S_RLI:
            begin
                ram_re     = 1'b1;
                ram_raddr  = li_reg;
                state_next = S_RUP;
            end
            S_RUP:
            begin
                acc_next   = alu_res;   // end of last available region
                state_next = (count_reg == '0) ? S_RDONE : S_RRD;
            end
            S_RRD:
            begin
                ram_re     = 1'b1;
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                op_a   = rd_base;
                op_b   = acc_reg;
                op_sub = 1'b1;
                if (!alu_carry && (rd_kind > KIND_AVAILABLE))
                begin
                    if (int'(rcnt_reg) < RESULT_CAP)
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            okind_next     = RES_RESERVED;
                            oaddr_next     = rd_base;
                            olen_next      = rd_len;
                            ofound_next    = 1'b0;
                            orcnt_next     = '0;
                            olast_next     = 1'b0;
                            rcnt_next      = rcnt_reg + CW'(1);
                            idx_next       = idx_reg + IW'(1);
                            state_next     = last_idx ? S_RDONE : S_RRD;
                        end
                    end
                    else
                    begin
                        // past the report cap: counted only
                        rcnt_next  = rcnt_reg + CW'(1);
                        idx_next   = idx_reg + IW'(1);
                        state_next = last_idx ? S_RDONE : S_RRD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = last_idx ? S_RDONE : S_RRD;
                end
            end
            S_RDONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    okind_next     = RES_SCAN_DONE;
                    oaddr_next     = '0;
                    olen_next      = '0;
                    ofound_next    = 1'b0;
                    orcnt_next     = rcnt_reg;
                    olast_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // status fields come straight from the status registers; they only change on a
    // load, which is taken only once the previous beat has left
    assign out_valid           = out_valid_reg;
    assign result_kind         = okind_reg;
    assign found_address       = oaddr_reg;
    assign found_length        = olen_reg;
    assign found               = ofound_reg;
    assign available_total     = sum_reg;
    assign last_available_slot = 5'(li_reg);
    assign loaded_count        = 6'(count_reg);
    assign reserved_count      = 6'(orcnt_reg);
    assign last                = olast_reg;

endmodule
